@@ src/ncma_pkg.sv @@
// ----------------------------------------------------------------------------
// Nine-channel moving average package
// Shared widths, window length and the constant reciprocal used to divide the
// running sums by the window length.
// ----------------------------------------------------------------------------
package ncma_pkg;

    localparam int CHANNELS   = 9;
    localparam int SAMPLE_W   = 16;
    localparam int WINDOW_LEN = 20;
    localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    // A running sum of WINDOW_LEN samples is exact in this many signed bits.
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);
    // Magnitude of a sum, held unsigned.
    localparam int ABS_W  = SUM_W;

    // Division by WINDOW_LEN is a multiply by ceil(2^K / WINDOW_LEN) and a
    // right shift by K, exact for every magnitude below 2^ABS_W.
    localparam int RECIP_SHIFT = ABS_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W     = ABS_W + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int PROD_W = ABS_W + RECIP_W;
    // The quotient magnitude reaches 2^(SAMPLE_W-1), so it needs one more bit.
    localparam int QUO_W  = SAMPLE_W + 1;

    localparam int ROW_W = CHANNELS * SAMPLE_W;

    typedef logic signed [SAMPLE_W-1:0]               t_sample;
    typedef logic signed [SUM_W-1:0]                  t_sum;
    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0]        t_row;

endpackage

@@ src/ncma_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data that holds its
// value while no read is requested.
// ----------------------------------------------------------------------------
module ncma_ram #(
    parameter int  DATA_W = 8,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/nine_channel_moving_average.sv @@
// ----------------------------------------------------------------------------
// Nine-channel moving average
// Boxcar average over the last WINDOW_LEN samples of nine sensor channels.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while o_stall is low, each item
// being a set of nine signed 16-bit samples, and returns one item of nine
// averages, each the sum of that channel's last WINDOW_LEN samples divided
// by WINDOW_LEN and truncated toward zero. Each item passes the stage 1, 2
// and 3 registers and then the output register. Throughput, unless a stall
// holds the flow, is one item per cycle, set by the per-channel running-sum
// registers, which every item updates exactly once. Before WINDOW_LEN items
// have arrived, the missing samples count as zeros. No clearing pass follows
// reset: a valid bit per ring row makes an unwritten row read as zero.
//
// Pipeline:
//   stage 1  the item is registered and the row it will overwrite is read
//            from the ring RAM (one row holds all nine channels);
//   stage 2  new sum = old sum + new sample - overwritten sample; the new
//            row is written back and the sums are registered;
//   stage 3  magnitude of each sum times the constant reciprocal;
//   output   shift, restore the sign and hold the result item.
// Each stage advances whenever the one after it is empty or moving, so
// bubbles close up. A waiting result blocks new input only once the three
// stages behind it are full, so the block holds up to four items.
// ----------------------------------------------------------------------------
module nine_channel_moving_average
    import ncma_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [15:0]    i_accel_x,
    input  logic signed [15:0]    i_accel_y,
    input  logic signed [15:0]    i_accel_z,
    input  logic signed [15:0]    i_compass_x,
    input  logic signed [15:0]    i_compass_y,
    input  logic signed [15:0]    i_compass_z,
    input  logic signed [15:0]    i_gyro_x,
    input  logic signed [15:0]    i_gyro_y,
    input  logic signed [15:0]    i_gyro_z,

    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [15:0]    o_avg_accel_x,
    output logic signed [15:0]    o_avg_accel_y,
    output logic signed [15:0]    o_avg_accel_z,
    output logic signed [15:0]    o_avg_compass_x,
    output logic signed [15:0]    o_avg_compass_y,
    output logic signed [15:0]    o_avg_compass_z,
    output logic signed [15:0]    o_avg_gyro_x,
    output logic signed [15:0]    o_avg_gyro_y,
    output logic signed [15:0]    o_avg_gyro_z
);

    // Handshake between the stages.
    logic w_accept;
    logic w_ld_s2;
    logic w_ld_s3;
    logic w_ld_out;
    logic w_s1_ready;
    logic w_s2_ready;
    logic w_s3_ready;

    // Write pointer and per-row valid bits of the ring.
    logic [SLOT_W-1:0]     r_wr_slot;
    logic [SLOT_W-1:0]     n_wr_slot;
    logic [WINDOW_LEN-1:0] r_row_vld;

    // Stage 1.
    t_row                  w_in_row;
    logic                  r_s1_vld;
    t_row                  r_s1_fresh;
    logic [SLOT_W-1:0]     r_s1_slot;
    logic                  r_s1_old_vld;
    t_row                  w_rd_row;
    t_row                  w_old_row;

    // Stage 2 and the running sums.
    t_sum                  r_sum [CHANNELS];
    t_sum                  n_sum [CHANNELS];
    logic                  r_s2_vld;
    t_sum                  r_s2_sum [CHANNELS];

    // Stage 3.
    logic                  r_s3_vld;
    logic [PROD_W-1:0]     r_s3_prod [CHANNELS];
    logic                  r_s3_neg [CHANNELS];
    logic [PROD_W-1:0]     n_prod [CHANNELS];

    // Output register.
    logic                  r_out_vld;
    t_sample               r_out [CHANNELS];
    t_sample               n_out [CHANNELS];

    // ------------------------------------------------------------------
    // Stage control: a stage may load when the next one is empty or is
    // itself loading this cycle.
    // ------------------------------------------------------------------
    assign w_ld_out   = r_s3_vld && (!r_out_vld || !i_stall);
    assign w_s3_ready = !r_s3_vld || w_ld_out;
    assign w_ld_s3    = r_s2_vld && w_s3_ready;
    assign w_s2_ready = !r_s2_vld || w_ld_s3;
    assign w_ld_s2    = r_s1_vld && w_s2_ready;
    assign w_s1_ready = !r_s1_vld || w_ld_s2;
    assign w_accept   = i_valid && w_s1_ready;
    assign o_stall    = !w_s1_ready;

    assign n_wr_slot = (r_wr_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : r_wr_slot + 1'b1;

    always_comb begin
        w_in_row[0] = i_accel_x;
        w_in_row[1] = i_accel_y;
        w_in_row[2] = i_accel_z;
        w_in_row[3] = i_compass_x;
        w_in_row[4] = i_compass_y;
        w_in_row[5] = i_compass_z;
        w_in_row[6] = i_gyro_x;
        w_in_row[7] = i_gyro_y;
        w_in_row[8] = i_gyro_z;
    end

    // ------------------------------------------------------------------
    // Ring storage. The row for the item in stage 1 is read as the item is
    // accepted and written back when the item leaves stage 1. Consecutive
    // items always use different rows, so no read meets a pending write.
    // ------------------------------------------------------------------
    ncma_ram #(
        .DATA_W (ROW_W),
        .DEPTH  (WINDOW_LEN)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_ld_s2),
        .i_wr_addr (r_s1_slot),
        .i_wr_data (r_s1_fresh),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_wr_slot),
        .o_rd_data (w_rd_row)
    );

    // A row that has never been written reads as zero through its valid bit.
    assign w_old_row = r_s1_old_vld ? w_rd_row : '0;

    // ------------------------------------------------------------------
    // Datapath per channel.
    // ------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_sum[c] = r_sum[c]
                     + t_sum'(t_sample'(r_s1_fresh[c]))
                     - t_sum'(t_sample'(w_old_row[c]));
        end
    end

    always_comb begin
        logic [ABS_W-1:0] mag;
        for (int c = 0; c < CHANNELS; c++) begin
            mag = r_s2_sum[c][SUM_W-1] ? ABS_W'(~r_s2_sum[c]) + 1'b1
                                        : ABS_W'(r_s2_sum[c]);
            n_prod[c] = PROD_W'(mag) * PROD_W'(RECIP);
        end
    end

    always_comb begin
        logic [QUO_W-1:0] quo;
        logic [QUO_W-1:0] sgn_quo;
        for (int c = 0; c < CHANNELS; c++) begin
            quo       = r_s3_prod[c][RECIP_SHIFT +: QUO_W];
            sgn_quo   = r_s3_neg[c] ? (~quo + 1'b1) : quo;
            n_out[c]  = t_sample'(sgn_quo[SAMPLE_W-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot <= '0;
            r_row_vld <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            if (w_accept) begin
                r_wr_slot <= n_wr_slot;
            end
            if (w_s1_ready) begin
                r_s1_vld <= w_accept;
            end
            if (w_s2_ready) begin
                r_s2_vld <= w_ld_s2;
            end
            if (w_s3_ready) begin
                r_s3_vld <= w_ld_s3;
            end
            if (w_ld_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
            if (w_ld_s2) begin
                r_row_vld[r_s1_slot] <= 1'b1;
                for (int c = 0; c < CHANNELS; c++) begin
                    r_sum[c] <= n_sum[c];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_fresh   <= w_in_row;
            r_s1_slot    <= r_wr_slot;
            r_s1_old_vld <= r_row_vld[r_wr_slot];
        end
        if (w_ld_s2) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_s2_sum[c] <= n_sum[c];
            end
        end
        if (w_ld_s3) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_s3_prod[c] <= n_prod[c];
                r_s3_neg[c]  <= r_s2_sum[c][SUM_W-1];
            end
        end
        if (w_ld_out) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_out[c] <= n_out[c];
            end
        end
    end

    assign o_valid         = r_out_vld;
    assign o_avg_accel_x   = r_out[0];
    assign o_avg_accel_y   = r_out[1];
    assign o_avg_accel_z   = r_out[2];
    assign o_avg_compass_x = r_out[3];
    assign o_avg_compass_y = r_out[4];
    assign o_avg_compass_z = r_out[5];
    assign o_avg_gyro_x    = r_out[6];
    assign o_avg_gyro_y    = r_out[7];
    assign o_avg_gyro_z    = r_out[8];

endmodule

@@ sim/nine_channel_moving_average_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nine-channel moving average testbench
// Drives sets of nine sensor samples through the block. It predicts each
// result item from its own running sums and compares it with what the block
// returns. Bursty input, patterned output stalls and one long output hold-off
// make the pipeline fill up and push back on its input.
// ----------------------------------------------------------------------------
module nine_channel_moving_average_tb
    import ncma_pkg::*;
();

    localparam int ITEM_TARGET     = 900;
    localparam int HOLD_OFF_AT     = 300;  // items sent before the long hold-off
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int TAIL_CYCLES     = 10;   // a margin beyond the four pipeline stages
    localparam int IDLE_LIMIT      = 1000;

    // Shapes of the random sample sequences. Held and toggled values fill the
    // whole window, so the averages reach both ends of the 16-bit range.
    typedef enum int {
        SEQ_HOLD,
        SEQ_TOGGLE,
        SEQ_SMALL,
        SEQ_NOISE
    } seq_kind_e;

    // Output stall patterns of the receiver.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_kind_e;

    // ------------------------------------------------------------------------
    // Prediction and checking. Each accepted item updates a private copy of
    // the rings and running sums; the nine truncated means are queued and
    // compared, in order, with the result items that the block returns.
    // ------------------------------------------------------------------------
    class window_average_checker;
        t_sample ring [CHANNELS][WINDOW_LEN];
        int      running_sum [CHANNELS];
        int      slot;
        t_row    expected_means [$];
        int      mismatches;
        string   names [CHANNELS];

        function new();
            foreach (ring[c, k]) ring[c][k] = '0;
            foreach (running_sum[c]) running_sum[c] = 0;
            slot       = 0;
            mismatches = 0;
            names = '{"avg_accel_x", "avg_accel_y", "avg_accel_z",
                      "avg_compass_x", "avg_compass_y", "avg_compass_z",
                      "avg_gyro_x", "avg_gyro_y", "avg_gyro_z"};
        endfunction

        function void note_sample_set(t_row samples);
            t_row    means;
            t_sample fresh;
            for (int c = 0; c < CHANNELS; c++) begin
                fresh = $signed(samples[c]);
                running_sum[c] += int'(fresh) - int'(ring[c][slot]);
                ring[c][slot] = fresh;
                // Integer division truncates toward zero, as the block must.
                means[c] = 16'(running_sum[c] / WINDOW_LEN);
            end
            slot = (slot + 1) % WINDOW_LEN;
            expected_means.push_back(means);
        endfunction

        function void check_averages(t_row got);
            t_row want;
            if (expected_means.size() == 0) begin
                mismatches++;
                $error("result item arrived with no expected averages waiting");
                return;
            end
            want = expected_means.pop_front();
            for (int c = 0; c < CHANNELS; c++) begin
                if (got[c] !== want[c]) begin
                    mismatches++;
                    $error("%s: expected %0d, got %0d", names[c],
                           $signed(want[c]), $signed(got[c]));
                end
            end
        endfunction

        function int pending();
            return expected_means.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [15:0]   i_accel_x, i_accel_y, i_accel_z;
    logic signed [15:0]   i_compass_x, i_compass_y, i_compass_z;
    logic signed [15:0]   i_gyro_x, i_gyro_y, i_gyro_z;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [15:0]   o_avg_accel_x, o_avg_accel_y, o_avg_accel_z;
    logic signed [15:0]   o_avg_compass_x, o_avg_compass_y, o_avg_compass_z;
    logic signed [15:0]   o_avg_gyro_x, o_avg_gyro_y, o_avg_gyro_z;

    window_average_checker avg_check = new();

    int sets_sent   = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    nine_channel_moving_average dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_accel_x       (i_accel_x),
        .i_accel_y       (i_accel_y),
        .i_accel_z       (i_accel_z),
        .i_compass_x     (i_compass_x),
        .i_compass_y     (i_compass_y),
        .i_compass_z     (i_compass_z),
        .i_gyro_x        (i_gyro_x),
        .i_gyro_y        (i_gyro_y),
        .i_gyro_z        (i_gyro_z),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_avg_accel_x   (o_avg_accel_x),
        .o_avg_accel_y   (o_avg_accel_y),
        .o_avg_accel_z   (o_avg_accel_z),
        .o_avg_compass_x (o_avg_compass_x),
        .o_avg_compass_y (o_avg_compass_y),
        .o_avg_compass_z (o_avg_compass_z),
        .o_avg_gyro_x    (o_avg_gyro_x),
        .o_avg_gyro_y    (o_avg_gyro_y),
        .o_avg_gyro_z    (o_avg_gyro_z)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, where the values seen
    // are those from before the edge, since both the block and the drivers
    // update with nonblocking assignments. An input item is noted before any
    // result of the same edge is checked.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                avg_check.note_sample_set({i_gyro_z, i_gyro_y, i_gyro_x,
                                           i_compass_z, i_compass_y, i_compass_x,
                                           i_accel_z, i_accel_y, i_accel_x});
            end
            if (o_valid && !i_stall) begin
                avg_check.check_averages({o_avg_gyro_z, o_avg_gyro_y, o_avg_gyro_x,
                                          o_avg_compass_z, o_avg_compass_y,
                                          o_avg_compass_x, o_avg_accel_z,
                                          o_avg_accel_y, o_avg_accel_x});
            end
        end
    end

    // Watchdog: a run that stops moving items on both sides for too long has
    // hung, however the stimulus was shaped.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks.
    // ------------------------------------------------------------------------

    // Offers one item and returns once it has been accepted, after any gap.
    // Between bursts the valid is dropped for a random gap; with no gap the
    // valid simply stays high for the next item.
    task automatic send_set(input t_row samples);
        int gap;
        i_valid     <= 1'b1;
        i_accel_x   <= samples[0];
        i_accel_y   <= samples[1];
        i_accel_z   <= samples[2];
        i_compass_x <= samples[3];
        i_compass_y <= samples[4];
        i_compass_z <= samples[5];
        i_gyro_x    <= samples[6];
        i_gyro_y    <= samples[7];
        i_gyro_z    <= samples[8];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sets_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            // Now and then a long burst, so that stretches pass without gaps.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(0, 30);
        end
    endtask

    function automatic t_row all_channels(input logic [15:0] value);
        t_row row;
        for (int c = 0; c < CHANNELS; c++) row[c] = value;
        return row;
    endfunction

    function automatic logic [15:0] pick_sample(input seq_kind_e kind,
                                                input logic [15:0] held,
                                                input int k);
        int near_zero;
        near_zero = $urandom_range(0, 90);
        case (kind)
            SEQ_HOLD:   return held;
            SEQ_TOGGLE: return k[0] ? ~held : held;
            SEQ_SMALL:  return 16'(near_zero - 45);
            default:    return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        seq_kind_e   kind;
        int          seq_len;
        logic [15:0] held [CHANNELS];
        t_row        row;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_accel_x   <= '0;
        i_accel_y   <= '0;
        i_accel_z   <= '0;
        i_compass_x <= '0;
        i_compass_y <= '0;
        i_compass_z <= '0;
        i_gyro_x    <= '0;
        i_gyro_y    <= '0;
        i_gyro_z    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items. The window starts full of zeros, so the first sums
        // are small and exercise truncation of negative means toward zero.
        send_set(all_channels(16'h0000));
        send_set(all_channels(16'h0001));
        send_set(all_channels(16'hFFFF));
        send_set(all_channels(16'hFFD9));   // sum -39: the mean truncates to -1
        send_set(all_channels(16'hFFED));   // a further -19
        send_set(all_channels(16'h0014));   // +20 brings the sum back toward zero
        send_set(all_channels(16'h7FFF));
        send_set(all_channels(16'h8000));
        send_set(all_channels(16'h7FFF));
        send_set({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                  16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
        send_set({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                  16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        send_set(all_channels(16'h5555));
        send_set(all_channels(16'hAAAA));
        send_set({16'h0FA0, 16'h0BB8, 16'h07D0, 16'h03E8, 16'h0000,
                  16'hFC18, 16'hF830, 16'hF448, 16'hF060});
        send_set(all_channels(16'h0000));

        // Random sequences. Most hold or toggle a value per channel for at
        // least a full window, so the sums reach their extremes; the rest is
        // values near zero and unstructured noise.
        while (sets_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: kind = SEQ_HOLD;
                4, 5:       kind = SEQ_TOGGLE;
                6, 7:       kind = SEQ_SMALL;
                default:    kind = SEQ_NOISE;
            endcase
            seq_len = (kind == SEQ_HOLD || kind == SEQ_TOGGLE)
                    ? $urandom_range(WINDOW_LEN, WINDOW_LEN + 12)
                    : $urandom_range(1, 30);
            for (int c = 0; c < CHANNELS; c++) begin
                case ($urandom_range(0, 3))
                    0:       held[c] = 16'h7FFF;
                    1:       held[c] = 16'h8000;
                    default: held[c] = 16'($urandom);
                endcase
            end
            for (int k = 0; k < seq_len; k++) begin
                for (int c = 0; c < CHANNELS; c++) row[c] = pick_sample(kind, held[c], k);
                send_set(row);
            end
        end

        i_valid <= 1'b0;
        while (avg_check.pending() != 0) @(posedge i_clk);
        // Give any stray result item the time to show itself.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (avg_check.mismatches == 0 && avg_check.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver. Stall patterns change from segment to segment. Once, after
    // HOLD_OFF_AT items, the output is held off for a long stretch while the
    // sender keeps offering, so that the pipeline fills and stalls its input.
    // ------------------------------------------------------------------------
    initial begin
        stall_kind_e pattern;
        int          seg_len;
        bit          held_off;

        held_off = 1'b0;
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && sets_sent >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            pattern = stall_kind_e'($urandom_range(0, 3));
            seg_len = $urandom_range(10, 80);
            for (int k = 0; k < seg_len; k++) begin
                case (pattern)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_stall <= (k % 3 == 2);
                endcase
                @(posedge i_clk);
            end
        end
    end

endmodule
